// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, with an explicit disable condition
`define ASSERT_IMPLY(lbl, clk, dis, a, b) \
    lbl: assert property (@(posedge clk) disable iff (dis) (a) |-> (b)) \
        else $error("assertion failed");

// next-cycle implication, with an explicit disable condition
`define ASSERT_NEXT(lbl, clk, dis, a, b) \
    lbl: assert property (@(posedge clk) disable iff (dis) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== sv/dbr_pkg.sv =====
// types and constants of the two-button debouncer with auto-repeat
`default_nettype none

package dbr_pkg;

    // per-button mode codes
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_IDLE       = 2'd0;
    localparam t_mode MODE_SETTLE_ON  = 2'd1;
    localparam t_mode MODE_HELD       = 2'd2;
    localparam t_mode MODE_SETTLE_OFF = 2'd3;

    // configuration register map
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_SETTLE = 2'd0;
    localparam t_cfg_idx REG_REPEAT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] SETTLE_RESET = 32'd50000;
    localparam logic [CFG_DATA_W-1:0] REPEAT_RESET = 32'd200000;

    // live configuration values
    typedef struct packed {
        logic [CFG_DATA_W-1:0] settle_time;
        logic [CFG_DATA_W-1:0] repeat_time;
    } t_cfg;

    // per-button update result
    typedef struct packed {
        t_mode mode;
        logic  fire;
    } t_btn_next;

endpackage

`default_nettype wire

// ===== sv/dbr_cfg.sv =====
// configuration registers: settle and repeat intervals
`default_nettype none

module dbr_cfg
    import dbr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire t_cfg_idx              i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // decode register writes, unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SETTLE: n_cfg.settle_time = i_cfg_data;
                REG_REPEAT: n_cfg.repeat_time = i_cfg_data;
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_time <= SETTLE_RESET;
            r_cfg.repeat_time <= REPEAT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== sv/dbr_button.sv =====
// next-state logic of one button debouncer
`default_nettype none

module dbr_button
    import dbr_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  wire t_mode                 i_mode,
    input  wire logic [TIME_WIDTH-1:0] i_deadline,
    input  wire logic [TIME_WIDTH-1:0] i_now,
    input  wire logic                  i_pin,
    input  wire t_cfg                  i_cfg,
    output t_btn_next                  o_next,
    output logic [TIME_WIDTH-1:0]      o_deadline
);

    logic                  w_expired;
    logic                  w_use_repeat;
    logic [CFG_DATA_W-1:0] w_interval;
    logic [TIME_WIDTH-1:0] w_new_deadline;

    // deadline passed: plain unsigned compare, no wrap handling
    assign w_expired = (i_deadline < i_now);

    // one adder, interval picked by mode: repeat when settling on or held with the pin high, else settle
    assign w_use_repeat = (i_mode == MODE_SETTLE_ON) || (i_mode == MODE_HELD && i_pin);
    assign w_interval = w_use_repeat ? i_cfg.repeat_time : i_cfg.settle_time;
    assign w_new_deadline = i_now + TIME_WIDTH'(w_interval);

    // mode transitions
    always_comb begin
        o_next.mode = i_mode;
        o_next.fire = 1'b0;
        o_deadline  = i_deadline;
        case (i_mode)
            MODE_IDLE: begin
                if (i_pin) begin
                    o_next.mode = MODE_SETTLE_ON;
                    o_deadline  = w_new_deadline;
                end
            end
            MODE_SETTLE_ON: begin
                if (w_expired) begin
                    o_next.mode = MODE_HELD;
                    o_next.fire = 1'b1;
                    o_deadline  = w_new_deadline;
                end
            end
            MODE_HELD: begin
                if (!i_pin) begin
                    o_next.mode = MODE_SETTLE_OFF;
                    o_deadline  = w_new_deadline;
                end else if (w_expired) begin
                    o_next.fire = 1'b1;
                    o_deadline  = w_new_deadline;
                end
            end
            default: begin
                if (w_expired) begin
                    o_next.mode = MODE_IDLE;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/dual_button_debounce_repeat.sv =====
// two-button debouncer with auto-repeat, one poll in and one click pair out per transfer
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------
//  poll in | i_valid / o_ready   | i_now, i_left_pin, i_right_pin
//  clicks  | o_valid / i_ready   | o_left_click, o_right_click
//  config  | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// a poll is taken into the input register, then the button update runs combinationally
// into the result register: one poll per cycle while the result register is not stalled.
// the input register refills in the cycle the result register is taken, so the
// block keeps full rate while the downstream side accepts every cycle.
// synchronous active-low reset puts both buttons idle with zero deadlines and
// loads the default settle and repeat intervals.
`default_nettype none

module dual_button_debounce_repeat
    import dbr_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [31:0]           i_now,
    input  wire logic                  i_left_pin,
    input  wire logic                  i_right_pin,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic                       o_left_click,
    output logic                       o_right_click,
    input  wire logic                  i_cfg_we,
    input  wire t_cfg_idx              i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg w_cfg;

    // input register
    logic                  r_in_valid;
    logic [TIME_WIDTH-1:0] r_now;
    logic                  r_left_pin;
    logic                  r_right_pin;

    // button state
    t_mode                 r_mode_l;
    t_mode                 r_mode_r;
    logic [TIME_WIDTH-1:0] r_dl_l;
    logic [TIME_WIDTH-1:0] r_dl_r;

    // result register
    logic r_out_valid;
    logic r_left_click;
    logic r_right_click;

    logic w_advance;
    logic w_take;

    t_btn_next             w_nx_l;
    t_btn_next             w_nx_r;
    logic [TIME_WIDTH-1:0] w_dl_l;
    logic [TIME_WIDTH-1:0] w_dl_r;

    t_mode                 n_mode_l;
    t_mode                 n_mode_r;
    logic [TIME_WIDTH-1:0] n_dl_l;
    logic [TIME_WIDTH-1:0] n_dl_r;
    logic                  n_left_click;
    logic                  n_right_click;

    dbr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // handshake: the stored poll moves on when the result slot is free or drains
    assign w_advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;
    assign w_take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_now       <= TIME_WIDTH'(i_now);
            r_left_pin  <= i_left_pin;
            r_right_pin <= i_right_pin;
        end
    end

    // per-button update
    dbr_button #(.TIME_WIDTH(TIME_WIDTH)) u_btn_l (
        .i_mode     (r_mode_l),
        .i_deadline (r_dl_l),
        .i_now      (r_now),
        .i_pin      (r_left_pin),
        .i_cfg      (w_cfg),
        .o_next     (w_nx_l),
        .o_deadline (w_dl_l)
    );

    dbr_button #(.TIME_WIDTH(TIME_WIDTH)) u_btn_r (
        .i_mode     (r_mode_r),
        .i_deadline (r_dl_r),
        .i_now      (r_now),
        .i_pin      (r_right_pin),
        .i_cfg      (w_cfg),
        .o_next     (w_nx_r),
        .o_deadline (w_dl_r)
    );

    // cross-copy: a left click pulls a settling right button along first,
    // then a right click pulls a settling left button along
    always_comb begin
        n_mode_l      = w_nx_l.mode;
        n_dl_l        = w_dl_l;
        n_left_click  = w_nx_l.fire;
        n_mode_r      = w_nx_r.mode;
        n_dl_r        = w_dl_r;
        n_right_click = w_nx_r.fire;
        if (n_left_click && n_mode_r == MODE_SETTLE_ON) begin
            n_mode_r      = n_mode_l;
            n_dl_r        = n_dl_l;
            n_right_click = 1'b1;
        end
        if (n_right_click && n_mode_l == MODE_SETTLE_ON) begin
            n_mode_l     = n_mode_r;
            n_dl_l       = n_dl_r;
            n_left_click = 1'b1;
        end
    end

    // button state commits once per poll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_l <= MODE_IDLE;
            r_mode_r <= MODE_IDLE;
            r_dl_l   <= '0;
            r_dl_r   <= '0;
        end else if (w_advance) begin
            r_mode_l <= n_mode_l;
            r_mode_r <= n_mode_r;
            r_dl_l   <= n_dl_l;
            r_dl_r   <= n_dl_r;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_left_click  <= n_left_click;
            r_right_click <= n_right_click;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_left_click  = r_left_click;
    assign o_right_click = r_right_click;

endmodule

`default_nettype wire

// ===== sv/dbr_checker.sv =====
// port-level checks of the debouncer handshakes, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module dbr_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_ready,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire logic o_left_click,
    input wire logic o_right_click
);

    logic [1:0] w_clicks;

    assign w_clicks = {o_left_click, o_right_click};

    // a stalled result keeps its clicks
    `ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_valid && !i_ready, o_valid && $stable(w_clicks))

    // reset empties both stages
    `ASSERT_NEXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, !o_valid && o_ready)

    // with no result pending the poll side is never stalled
    `ASSERT_IMPLY(a_empty_ready, i_clk, !i_rst_n, !o_valid, o_ready)

    // a fresh result comes from an earlier poll transfer, through the input register
    `ASSERT_IMPLY(a_result_source, i_clk, !i_rst_n, $rose(o_valid), $past(i_valid && o_ready, 2))

endmodule

bind dual_button_debounce_repeat dbr_checker u_dbr_checker (.*);

`default_nettype wire

// ===== bench/tb_dual_button_debounce_repeat.sv =====
// testbench of the two-button debouncer with auto-repeat: directed polls, then random phases
`default_nettype none

module tb_dual_button_debounce_repeat;
    import dbr_pkg::*;

    // register indexes that the block must ignore
    localparam t_cfg_idx REG_SPARE_A = 2'd2;
    localparam t_cfg_idx REG_SPARE_B = 2'd3;

    localparam int IDLE_PCT = 18;
    localparam int STALL_LIMIT = 1000;
    localparam int ITEMS_PER_PHASE = 140;

    typedef struct packed {
        logic left_click;
        logic right_click;
    } t_click_pair;

    // predicts the click pair of every poll and checks the block against it
    class click_scoreboard;
        logic [31:0] settle_ticks;
        logic [31:0] repeat_ticks;
        t_mode       mode [2];
        logic [31:0] deadline [2];
        t_click_pair clicks_due [$];
        int          errors;

        function new();
            settle_ticks = SETTLE_RESET;
            repeat_ticks = REPEAT_RESET;
            mode[0] = MODE_IDLE;
            mode[1] = MODE_IDLE;
            deadline[0] = '0;
            deadline[1] = '0;
            errors = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [31:0] data);
            case (idx)
                REG_SETTLE: settle_ticks = data;
                REG_REPEAT: repeat_ticks = data;
                default: ;
            endcase
        endfunction

        // one button's mode step, returns 1 when it clicks
        function bit advance_button(int b, logic [31:0] now, bit pressed);
            bit          fire;
            logic [31:0] dl;
            fire = 1'b0;
            dl = deadline[b];
            case (mode[b])
                MODE_IDLE: begin
                    if (pressed) begin
                        deadline[b] = now + settle_ticks;
                        mode[b] = MODE_SETTLE_ON;
                    end
                end
                MODE_SETTLE_ON: begin
                    if (dl < now) begin
                        fire = 1'b1;
                        deadline[b] = now + repeat_ticks;
                        mode[b] = MODE_HELD;
                    end
                end
                MODE_HELD: begin
                    if (!pressed) begin
                        deadline[b] = now + settle_ticks;
                        mode[b] = MODE_SETTLE_OFF;
                    end else if (dl < now) begin
                        fire = 1'b1;
                        deadline[b] = now + repeat_ticks;
                    end
                end
                default: begin
                    if (dl < now)
                        mode[b] = MODE_IDLE;
                end
            endcase
            return fire;
        endfunction

        function void note_poll(logic [31:0] now, bit lp, bit rp);
            bit lc;
            bit rc;
            lc = advance_button(0, now, lp);
            rc = advance_button(1, now, rp);
            // a click drags a button still settling on into the same state, left first
            if (lc && mode[1] == MODE_SETTLE_ON) begin
                mode[1] = mode[0];
                deadline[1] = deadline[0];
                rc = 1'b1;
            end
            if (rc && mode[0] == MODE_SETTLE_ON) begin
                mode[0] = mode[1];
                deadline[0] = deadline[1];
                lc = 1'b1;
            end
            clicks_due.push_back('{left_click: lc, right_click: rc});
        endfunction

        function void check_clicks(logic lc, logic rc);
            t_click_pair want;
            if (clicks_due.size() == 0) begin
                $error("click transfer with no poll waiting: left %0b right %0b", lc, rc);
                errors++;
                return;
            end
            want = clicks_due.pop_front();
            if (lc !== want.left_click) begin
                $error("left_click: expected %0b, actual %0b", want.left_click, lc);
                errors++;
            end
            if (rc !== want.right_click) begin
                $error("right_click: expected %0b, actual %0b", want.right_click, rc);
                errors++;
            end
        endfunction

        function int pending();
            return clicks_due.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_now;
    logic        i_left_pin;
    logic        i_right_pin;
    logic        o_valid;
    logic        i_ready;
    logic        o_left_click;
    logic        o_right_click;
    logic        i_cfg_we;
    t_cfg_idx    i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    click_scoreboard sb;
    bit calm;
    int stall_cycles;

    dual_button_debounce_repeat i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_now         (i_now),
        .i_left_pin    (i_left_pin),
        .i_right_pin   (i_right_pin),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_left_click  (o_left_click),
        .o_right_click (o_right_click),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // downstream side stalls at random, unless calm is set
    always @(posedge i_clk) begin
        i_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // click transfers
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_clicks(o_left_click, o_right_click);
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // one poll transfer, with random idle cycles ahead of it
    task automatic send_poll(input logic [31:0] now, input bit lp, input bit rp);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_now <= now;
        i_left_pin <= lp;
        i_right_pin <= rp;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        sb.note_poll(now, lp, rp);
    endtask

    // stop polling and let every click pair come out
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // leaves the write enable high, the caller lowers it
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_intervals(input logic [31:0] settle_ticks, input logic [31:0] rpt_ticks,
                                 input bit spare);
        write_reg(REG_SETTLE, settle_ticks);
        write_reg(REG_REPEAT, rpt_ticks);
        if (spare) begin
            write_reg(REG_SPARE_A, $urandom);
            write_reg(REG_SPARE_B, $urandom);
        end
        i_cfg_we <= 1'b0;
    endtask

    // mostly press and release runs on rising time, some bounce and time jumps
    task automatic run_phase(input logic [31:0] start, input int unsigned step_max,
                             input int unsigned hold_max);
        logic [31:0] t;
        bit          level [2];
        int unsigned hold [2];
        bit          pin [2];
        t = start;
        level[0] = 1'b0;
        level[1] = 1'b0;
        hold[0] = $urandom_range(hold_max, 1);
        hold[1] = $urandom_range(hold_max, 1);
        for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if ($urandom_range(99) < 4) begin
                send_poll($urandom, $urandom_range(1), $urandom_range(1));
            end else begin
                t = t + $urandom_range(step_max, 0);
                for (int b = 0; b < 2; b++) begin
                    if (hold[b] == 0) begin
                        level[b] = !level[b];
                        hold[b] = $urandom_range(hold_max, 1);
                    end else begin
                        hold[b]--;
                    end
                    pin[b] = level[b] ^ ($urandom_range(99) < 5);
                end
                send_poll(t, pin[0], pin[1]);
            end
        end
    endtask

    // stimulus
    initial begin
        sb = new();
        calm = 1'b0;
        stall_cycles = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_now <= '0;
        i_left_pin <= 1'b0;
        i_right_pin <= 1'b0;
        i_ready <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_SETTLE;
        i_cfg_data <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default intervals: settle edge, cross copy both ways, wrap, settling ignores pins
        send_poll(32'd0, 1'b0, 1'b0);
        send_poll(32'd10, 1'b1, 1'b0);
        send_poll(32'd20000, 1'b1, 1'b1);
        send_poll(32'd50010, 1'b1, 1'b1);
        send_poll(32'd50011, 1'b1, 1'b1);
        send_poll(32'd250012, 1'b1, 1'b1);
        send_poll(32'd250013, 1'b0, 1'b1);
        send_poll(32'd300014, 1'b0, 1'b1);
        send_poll(32'd450013, 1'b1, 1'b1);
        send_poll(32'hFFFF_FFFF, 1'b1, 1'b1);
        send_poll(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_poll(32'd0, 1'b0, 1'b0);
        send_poll(32'd60000, 1'b0, 1'b0);
        send_poll(32'd70000, 1'b1, 1'b0);
        send_poll(32'd80000, 1'b0, 1'b0);
        send_poll(32'd120001, 1'b0, 1'b0);
        send_poll(32'd120002, 1'b0, 1'b0);
        drain();

        // zero intervals, spare indexes written too
        set_intervals(32'd0, 32'd0, 1'b1);
        send_poll(32'd5, 1'b1, 1'b1);
        send_poll(32'd5, 1'b1, 1'b1);
        send_poll(32'd6, 1'b1, 1'b1);
        send_poll(32'd7, 1'b1, 1'b1);
        send_poll(32'd7, 1'b0, 1'b0);
        send_poll(32'd8, 1'b0, 1'b0);
        drain();

        // random phases over several interval settings
        set_intervals(32'd1, 32'd1, 1'b0);
        run_phase(32'd0, 3, 12);
        drain();
        set_intervals(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        run_phase($urandom, 3, 10);
        drain();
        set_intervals(32'd20, 32'd50, 1'b1);
        run_phase(32'hFFFF_FF00, 6, 60);
        drain();
        calm = 1'b1;
        set_intervals($urandom_range(40, 1), $urandom_range(80, 1), 1'b0);
        run_phase($urandom, 8, 50);
        drain();
        calm = 1'b0;
        set_intervals(SETTLE_RESET, REPEAT_RESET, 1'b0);
        run_phase($urandom, 20000, 40);
        drain();
        set_intervals(32'd0, 32'd0, 1'b0);
        run_phase($urandom, 2, 8);
        drain();
        set_intervals($urandom_range(200, 1), $urandom_range(400, 1), 1'b0);
        run_phase(32'hFFFF_F000, 30, 60);
        drain();
        set_intervals($urandom, $urandom, 1'b1);
        run_phase($urandom, 32'hFFFF_FFFF, 20);
        drain();

        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
